FILE: src/matrix_transform_from_pair_macros.svh
// Assertion shorthands used by the top-level file, which checks itself.
`ifndef MATRIX_TRANSFORM_FROM_PAIR_MACROS_SVH
`define MATRIX_TRANSFORM_FROM_PAIR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MTFP_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MTFP_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mtfp_pkg.sv
package mtfp_pkg;

    localparam int ELEM_W     = 16;
    localparam int IDX_W      = 2;
    localparam int ADDR_W     = 4;
    localparam int SIZE_W     = 3;
    localparam int MAX_SIZE   = 4;
    localparam int COF_W      = 50;
    localparam int PROD_W     = COF_W + ELEM_W;
    localparam int ACC_W      = 68;
    localparam int FRAC_SHIFT = 17;
    localparam int DIVN_W     = ACC_W + FRAC_SHIFT + 1;
    localparam int DIVD_W     = ACC_W + 1;
    localparam int OUT_W      = 32;
    localparam int STORE_DEPTH = 16;

    localparam logic [1:0] CMD_LOAD_SRC = 2'd0;
    localparam logic [1:0] CMD_LOAD_DST = 2'd1;
    localparam logic [1:0] CMD_SOLVE    = 2'd2;

    typedef struct packed {
        logic              ld_src;
        logic              ld_dst;
        logic [ADDR_W-1:0] rd_s_addr;
        logic [ADDR_W-1:0] rd_d_addr;
        logic [ADDR_W-1:0] rd_c_addr;
        logic              prod_init;
        logic              prod_mul;
        logic              acc_clr;
        logic              acc_add;
        logic              term_neg;
        logic              num_mac;
        logic              cof_wr;
        logic              cof_neg;
        logic [ADDR_W-1:0] cof_addr;
        logic              det_save;
        logic              div_start;
        logic              emit_val;
        logic              emit_sing;
        logic [IDX_W-1:0]  out_row;
        logic [IDX_W-1:0]  out_col;
        logic              out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic det_zero;
        logic div_done;
    } t_dp_sts;

endpackage

FILE: src/mtfp_ram.sv
module mtfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/mtfp_div.sv
module mtfp_div #(
    parameter int NW = 86,
    parameter int DW = 69
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [NW-1:0] o_quot,
    output logic          o_done
);

    localparam int CNT_W = $clog2(NW);

    logic [NW-1:0]    r_q;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic [DW:0]      rem2;
    logic             ge;
    logic [DW:0]      diff;

    // One quotient bit per cycle, most significant first.
    always_comb begin
        rem2 = {r_rem, r_q[NW-1]};
        ge   = rem2 >= {1'b0, r_div};
        diff = rem2 - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(NW - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_q   <= {r_q[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : rem2[DW-1:0];
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

FILE: src/mtfp_dp.sv
module mtfp_dp
    import mtfp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [IDX_W-1:0]         i_row_index,
    input  logic [IDX_W-1:0]         i_col_index,
    input  logic signed [ELEM_W-1:0] i_element_value,
    output t_dp_sts                  o_sts,
    output logic                     o_strobe,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic signed [OUT_W-1:0]  o_out_value,
    output logic                     o_singular,
    output logic                     o_saturated,
    output logic                     o_last
);

    logic [ELEM_W-1:0]        s_rdata;
    logic [ELEM_W-1:0]        d_rdata;
    logic [COF_W-1:0]         c_rdata;
    logic [ADDR_W-1:0]        ld_addr;
    logic signed [COF_W-1:0]  mul_a;
    logic signed [ELEM_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  mul_ext;
    logic signed [COF_W-1:0]  acc_lo;
    logic [COF_W-1:0]         cof_wdata;
    logic [ACC_W-1:0]         acc_abs;
    logic [ACC_W-1:0]         r_det_abs;
    logic                     r_det_neg;
    logic                     r_neg;
    logic [DIVN_W-1:0]        dividend;
    logic [DIVD_W-1:0]        divisor;
    logic [DIVN_W-1:0]        quot;
    logic                     div_done;
    logic                     sat;
    logic [OUT_W-1:0]         val;
    logic                     r_strobe;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic [OUT_W-1:0]         r_out_value;
    logic                     r_singular;
    logic                     r_saturated;
    logic                     r_last;

    assign ld_addr = {i_row_index, i_col_index};

    mtfp_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_src),
        .i_waddr (ld_addr),
        .i_wdata (i_element_value),
        .i_raddr (i_cmd.rd_s_addr),
        .o_rdata (s_rdata)
    );

    mtfp_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_dst_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_dst),
        .i_waddr (ld_addr),
        .i_wdata (i_element_value),
        .i_raddr (i_cmd.rd_d_addr),
        .o_rdata (d_rdata)
    );

    mtfp_ram #(.WIDTH(COF_W), .DEPTH(STORE_DEPTH)) u_cof_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cof_wr),
        .i_waddr (i_cmd.cof_addr),
        .i_wdata (cof_wdata),
        .i_raddr (i_cmd.rd_c_addr),
        .o_rdata (c_rdata)
    );

    // The one multiplier serves both the permutation products and the
    // numerator sums; a running product never exceeds three factors before
    // its final step, so its low bits are enough as an operand.
    always_comb begin
        mul_a    = i_cmd.num_mac ? signed'(c_rdata) : r_prod[COF_W-1:0];
        mul_b    = i_cmd.num_mac ? signed'(d_rdata) : signed'(s_rdata);
        mul_p    = mul_a * mul_b;
        prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        mul_ext  = {{(ACC_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};
        acc_lo   = r_acc[COF_W-1:0];
        cof_wdata = i_cmd.cof_neg ? -acc_lo : acc_lo;
        acc_abs  = r_acc[ACC_W-1] ? -r_acc : r_acc;
        dividend = {1'b0, acc_abs, {FRAC_SHIFT{1'b0}}} + {{(DIVN_W-ACC_W){1'b0}}, r_det_abs};
        divisor  = {r_det_abs, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_init) begin
            r_prod <= PROD_W'(1);
        end else if (i_cmd.prod_mul) begin
            r_prod <= mul_p;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= i_cmd.term_neg ? r_acc - prod_ext : r_acc + prod_ext;
        end else if (i_cmd.num_mac) begin
            r_acc <= r_acc + mul_ext;
        end
        if (i_cmd.det_save) begin
            r_det_abs <= acc_abs;
            r_det_neg <= r_acc[ACC_W-1];
        end
        if (i_cmd.div_start) begin
            r_neg <= r_acc[ACC_W-1] ^ r_det_neg;
        end
    end

    mtfp_div #(.NW(DIVN_W), .DW(DIVD_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    // Saturate the rounded magnitude to the signed Q16.16 range.
    always_comb begin
        if (r_neg) begin
            sat = (|quot[DIVN_W-1:OUT_W]) || (quot[OUT_W-1] && (|quot[OUT_W-2:0]));
            val = sat ? {1'b1, {(OUT_W-1){1'b0}}} : -quot[OUT_W-1:0];
        end else begin
            sat = |quot[DIVN_W-1:OUT_W-1];
            val = sat ? {1'b0, {(OUT_W-1){1'b1}}} : quot[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_val | i_cmd.emit_sing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sing) begin
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_value <= '0;
            r_singular  <= 1'b1;
            r_saturated <= 1'b0;
            r_last      <= 1'b1;
        end else if (i_cmd.emit_val) begin
            r_out_row   <= i_cmd.out_row;
            r_out_col   <= i_cmd.out_col;
            r_out_value <= val;
            r_singular  <= 1'b0;
            r_saturated <= sat;
            r_last      <= i_cmd.out_last;
        end
    end

    assign o_sts.det_zero = (r_det_abs == '0);
    assign o_sts.div_done = div_done;
    assign o_strobe       = r_strobe;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_out_value    = r_out_value;
    assign o_singular     = r_singular;
    assign o_saturated    = r_saturated;
    assign o_last         = r_last;

endmodule

FILE: src/mtfp_ctrl.sv
module mtfp_ctrl
    import mtfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_command,
    input  logic [SIZE_W-1:0] i_size,
    input  t_dp_sts           i_sts,
    output logic              o_busy,
    output t_dp_cmd           o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_TERM, S_FETCH, S_MUL, S_TERM_END, S_MINOR_END,
        S_DET_CHK, S_SING, S_NSETUP, S_NFETCH, S_NMAC, S_DIV_GO, S_DIV_WAIT,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_m, n_m;
    logic              r_det_phase, n_det_phase;
    logic [IDX_W-1:0]  r_row, n_row;
    logic [IDX_W-1:0]  r_col, n_col;
    logic [IDX_W-1:0]  r_t, n_t;
    logic [IDX_W-1:0]  r_k, n_k;
    logic              r_c1, n_c1;
    logic [1:0]        r_c2, n_c2;
    logic [1:0]        r_c3, n_c3;
    logic [SIZE_W-1:0] ex_r;
    logic [SIZE_W-1:0] ex_c;
    logic [IDX_W-1:0]  pcol;
    logic [IDX_W-1:0]  srow;
    logic [IDX_W-1:0]  scol;
    logic              row_end;
    logic              col_end;
    logic              k_end;
    logic              t_end;
    logic              max1;
    logic [1:0]        max2;
    logic [1:0]        max3;
    logic              last_perm;

    // Column that a permutation places at minor row t. The digits select the
    // swaps of a shuffle from the top position down, so the first m! codes
    // only permute the first m columns.
    function automatic logic [IDX_W-1:0] perm_at(input logic c1, input logic [1:0] c2,
                                                 input logic [1:0] c3,
                                                 input logic [IDX_W-1:0] t);
        logic [IDX_W-1:0] a [4];
        logic [IDX_W-1:0] tmp;
        a[0] = 2'd0;
        a[1] = 2'd1;
        a[2] = 2'd2;
        a[3] = 2'd3;
        tmp = a[3];
        a[3] = a[2'd3 - c3];
        a[2'd3 - c3] = tmp;
        tmp = a[2];
        a[2] = a[2'd2 - c2];
        a[2'd2 - c2] = tmp;
        tmp = a[1];
        a[1] = a[2'd1 - {1'b0, c1}];
        a[2'd1 - {1'b0, c1}] = tmp;
        return a[t];
    endfunction

    always_comb begin
        ex_r    = r_det_phase ? 3'd4 : {1'b0, r_row};
        ex_c    = r_det_phase ? 3'd4 : {1'b0, r_col};
        pcol    = perm_at(r_c1, r_c2, r_c3, r_t);
        srow    = ({1'b0, r_t} < ex_r) ? r_t : r_t + 2'd1;
        scol    = ({1'b0, pcol} < ex_c) ? pcol : pcol + 2'd1;
        row_end = ({1'b0, r_row} == i_size - 3'd1);
        col_end = ({1'b0, r_col} == i_size - 3'd1);
        k_end   = ({1'b0, r_k} == i_size - 3'd1);
        t_end   = ({1'b0, r_t} == r_m - 3'd1);
        max1    = (r_m >= 3'd2);
        max2    = (r_m >= 3'd3) ? 2'd2 : 2'd0;
        max3    = (r_m >= 3'd4) ? 2'd3 : 2'd0;
        last_perm = (r_c1 == max1) && (r_c2 == max2) && (r_c3 == max3);
    end

    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_det_phase = r_det_phase;
        n_row       = r_row;
        n_col       = r_col;
        n_t         = r_t;
        n_k         = r_k;
        n_c1        = r_c1;
        n_c2        = r_c2;
        n_c3        = r_c3;
        o_cmd           = '0;
        o_cmd.rd_s_addr = {srow, scol};
        o_cmd.rd_d_addr = {r_row, r_k};
        o_cmd.rd_c_addr = {r_col, r_k};
        o_cmd.cof_addr  = {r_row, r_col};
        o_cmd.cof_neg   = r_row[0] ^ r_col[0];
        o_cmd.term_neg  = r_c1 ^ (r_c2 != 2'd0) ^ (r_c3 != 2'd0);
        o_cmd.out_row   = r_row;
        o_cmd.out_col   = r_col;
        o_cmd.out_last  = row_end && col_end;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_command)
                        CMD_LOAD_SRC: o_cmd.ld_src = 1'b1;
                        CMD_LOAD_DST: o_cmd.ld_dst = 1'b1;
                        CMD_SOLVE: begin
                            n_m         = i_size;
                            n_det_phase = 1'b1;
                            n_state     = S_SETUP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SETUP: begin
                o_cmd.acc_clr = 1'b1;
                n_c1    = 1'b0;
                n_c2    = 2'd0;
                n_c3    = 2'd0;
                n_state = S_TERM;
            end
            S_TERM: begin
                o_cmd.prod_init = 1'b1;
                n_t     = '0;
                n_state = (r_m == 3'd0) ? S_TERM_END : S_FETCH;
            end
            S_FETCH: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.prod_mul = 1'b1;
                n_t     = r_t + 2'd1;
                n_state = t_end ? S_TERM_END : S_FETCH;
            end
            S_TERM_END: begin
                o_cmd.acc_add = 1'b1;
                if (last_perm) begin
                    n_state = S_MINOR_END;
                end else begin
                    n_state = S_TERM;
                    if (r_c1 != max1) begin
                        n_c1 = 1'b1;
                    end else begin
                        n_c1 = 1'b0;
                        if (r_c2 != max2) begin
                            n_c2 = r_c2 + 2'd1;
                        end else begin
                            n_c2 = 2'd0;
                            n_c3 = r_c3 + 2'd1;
                        end
                    end
                end
            end
            S_MINOR_END: begin
                if (r_det_phase) begin
                    o_cmd.det_save = 1'b1;
                    n_state = S_DET_CHK;
                end else begin
                    o_cmd.cof_wr = 1'b1;
                    if (col_end) begin
                        n_col = '0;
                        if (row_end) begin
                            n_row   = '0;
                            n_state = S_NSETUP;
                        end else begin
                            n_row   = r_row + 2'd1;
                            n_state = S_SETUP;
                        end
                    end else begin
                        n_col   = r_col + 2'd1;
                        n_state = S_SETUP;
                    end
                end
            end
            S_DET_CHK: begin
                if (i_sts.det_zero) begin
                    n_state = S_SING;
                end else begin
                    n_det_phase = 1'b0;
                    n_m     = i_size - 3'd1;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = S_SETUP;
                end
            end
            S_SING: begin
                o_cmd.emit_sing = 1'b1;
                n_state = S_IDLE;
            end
            S_NSETUP: begin
                o_cmd.acc_clr = 1'b1;
                n_k     = '0;
                n_state = S_NFETCH;
            end
            S_NFETCH: begin
                n_state = S_NMAC;
            end
            S_NMAC: begin
                o_cmd.num_mac = 1'b1;
                n_k     = r_k + 2'd1;
                n_state = k_end ? S_DIV_GO : S_NFETCH;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_val = 1'b1;
                if (col_end) begin
                    n_col = '0;
                    if (row_end) begin
                        n_row   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + 2'd1;
                        n_state = S_NSETUP;
                    end
                end else begin
                    n_col   = r_col + 2'd1;
                    n_state = S_NSETUP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m         <= '0;
            r_det_phase <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_t         <= '0;
            r_k         <= '0;
            r_c1        <= 1'b0;
            r_c2        <= 2'd0;
            r_c3        <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_m         <= n_m;
            r_det_phase <= n_det_phase;
            r_row       <= n_row;
            r_col       <= n_col;
            r_t         <= n_t;
            r_k         <= n_k;
            r_c1        <= n_c1;
            r_c2        <= n_c2;
            r_c3        <= n_c3;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: src/matrix_transform_from_pair.sv
// A load leaves the block idle, and another load may follow in the next cycle.
// A solve keeps busy high through the determinant, the cofactors and each
// result in turn (only the singular one if the determinant is zero), paced
// by the one shared multiplier and the 86-step bit-serial divider.
// Results appear as single-cycle strobes; the receiver cannot stall them.
// Synchronous active-low reset sets the size to 4; the stores are not cleared.
`include "matrix_transform_from_pair_macros.svh"

module matrix_transform_from_pair
    import mtfp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_command,
    input  logic [IDX_W-1:0]         i_row_index,
    input  logic [IDX_W-1:0]         i_col_index,
    input  logic signed [ELEM_W-1:0] i_element_value,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [SIZE_W-1:0]        i_cfg_data,
    output logic                     o_strobe,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic signed [OUT_W-1:0]  o_out_value,
    output logic                     o_singular,
    output logic                     o_saturated,
    output logic                     o_last
);

    logic [SIZE_W-1:0] r_matrix_size;
    logic [SIZE_W-1:0] size_eff;
    logic              accept;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    // The size may not change under a beat that is being taken.
    assign o_cfg_ready = !busy && !start;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= SIZE_W'(MAX_SIZE);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_matrix_size <= i_cfg_data;
        end
    end

    // A size of zero acts as one; anything above the largest size is clamped.
    always_comb begin
        if (r_matrix_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (r_matrix_size > SIZE_W'(MAX_SIZE)) begin
            size_eff = SIZE_W'(MAX_SIZE);
        end else begin
            size_eff = r_matrix_size;
        end
    end

    mtfp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_size    (size_eff),
        .i_sts     (sts),
        .o_busy    (busy),
        .o_cmd     (cmd)
    );

    mtfp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .o_sts           (sts),
        .o_strobe        (o_strobe),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_out_value     (o_out_value),
        .o_singular      (o_singular),
        .o_saturated     (o_saturated),
        .o_last          (o_last)
    );

    `MTFP_ASSERT_NEXT(a_solve_busy, i_clk, i_rst_n, accept && (i_command == CMD_SOLVE), busy, "solve beat did not raise busy")
    `MTFP_ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, accept && (i_command != CMD_SOLVE), !busy && !o_strobe, "load beat left the block busy")
    `MTFP_ASSERT_NOW(a_sing_last, i_clk, i_rst_n, o_strobe && o_singular, o_last && (o_out_value == '0) && !o_saturated, "singular result malformed")
    `MTFP_ASSERT_NOW(a_sat_value, i_clk, i_rst_n, o_strobe && o_saturated, (o_out_value == 32'sh7FFFFFFF) || (o_out_value == -32'sh80000000), "saturated value not at a limit")

endmodule

FILE: dv/matrix_transform_from_pair_tb.sv
module matrix_transform_from_pair_tb;
    import mtfp_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [15:0] val;
    } beat_t;

    typedef struct packed {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        singular;
        logic        saturated;
        logic        last;
    } elem_t;

    typedef struct {
        beat_t       b;
        bit          typed;
        logic [31:0] xvalue;
        logic        xsing;
        logic        xsat;
    } dir_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_command;
    logic [IDX_W-1:0]  i_row_index;
    logic [IDX_W-1:0]  i_col_index;
    logic signed [ELEM_W-1:0] i_element_value;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data;
    logic              o_strobe;
    logic [IDX_W-1:0]  o_out_row;
    logic [IDX_W-1:0]  o_out_col;
    logic signed [OUT_W-1:0] o_out_value;
    logic              o_singular;
    logic              o_saturated;
    logic              o_last;

    matrix_transform_from_pair uut (.*);

    logic signed [15:0] src_mat [4][4];
    logic signed [15:0] dst_mat [4][4];
    int                 dim;
    elem_t              pending_elems [$];
    int                 mismatches;
    int                 items_sent;
    int                 burst_left;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint det_upto3(int m, longint a [3][3]);
        case (m)
            0: return 1;
            1: return a[0][0];
            2: return a[0][0] * a[1][1] - a[1][0] * a[0][1];
            default: return a[0][0] * (a[1][1] * a[2][2] - a[2][1] * a[1][2])
                          - a[1][0] * (a[0][1] * a[2][2] - a[2][1] * a[0][2])
                          + a[2][0] * (a[0][1] * a[1][2] - a[1][1] * a[0][2]);
        endcase
    endfunction

    // Works out T = D * adj(S) / det(S) for the current size and queues it.
    task automatic solve_transform();
        longint            minor [3][3];
        longint            cof [4][4];
        logic signed [127:0] det_s, num;
        logic [127:0]      ad, an, q;
        logic              neg;
        elem_t             e;
        for (int r = 0; r < dim; r++) begin
            for (int c = 0; c < dim; c++) begin
                for (int i = 0; i < dim - 1; i++)
                    for (int j = 0; j < dim - 1; j++)
                        minor[i][j] = src_mat[i < r ? i : i + 1][j < c ? j : j + 1];
                cof[r][c] = det_upto3(dim - 1, minor);
                if ((r + c) % 2 == 1) cof[r][c] = -cof[r][c];
            end
        end
        det_s = 0;
        for (int r = 0; r < dim; r++)
            det_s += 128'(longint'(src_mat[r][0])) * 128'(cof[r][0]);
        if (det_s == 0) begin
            e = '{row: 0, col: 0, value: 0, singular: 1, saturated: 0, last: 1};
            pending_elems.push_back(e);
            return;
        end
        ad = det_s < 0 ? -det_s : det_s;
        for (int i = 0; i < dim; i++) begin
            for (int j = 0; j < dim; j++) begin
                num = 0;
                for (int k = 0; k < dim; k++)
                    num += 128'(longint'(dst_mat[i][k])) * 128'(cof[j][k]);
                an = num < 0 ? -num : num;
                neg = (num < 0) != (det_s < 0);
                q = ((an << 17) + ad) / (ad << 1);
                e.row = 2'(i);
                e.col = 2'(j);
                e.singular = 1'b0;
                e.last = (i == dim - 1 && j == dim - 1);
                if (neg) begin
                    e.saturated = q > 128'h8000_0000;
                    e.value = e.saturated ? 32'h8000_0000 : 32'(-q);
                end else begin
                    e.saturated = q > 128'h7FFF_FFFF;
                    e.value = e.saturated ? 32'h7FFF_FFFF : q[31:0];
                end
                pending_elems.push_back(e);
            end
        end
    endtask

    // Drives one beat and waits for it to be taken; the sender then idles at random.
    task automatic send(beat_t b, bit predict = 1);
        @(negedge i_clk);
        start = 1'b1;
        i_command = b.cmd;
        i_row_index = b.row;
        i_col_index = b.col;
        i_element_value = b.val;
        do @(posedge i_clk); while (busy);
        items_sent++;
        case (b.cmd)
            CMD_LOAD_SRC: src_mat[b.row][b.col] = b.val;
            CMD_LOAD_DST: dst_mat[b.row][b.col] = b.val;
            CMD_SOLVE: if (predict) solve_transform();
            default: ;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge i_clk);
                start = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_elems.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_size(logic [2:0] v);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        dim = v == 0 ? 1 : (v > 4 ? 4 : v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] rand_elem(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom_range(0, 255) - 128);
        endcase
    endfunction

    always @(posedge i_clk) begin
        elem_t got, want;
        if (i_rst_n && o_strobe) begin
            got = '{o_out_row, o_out_col, o_out_value, o_singular, o_saturated, o_last};
            if (pending_elems.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: row %0d col %0d value %h",
                             got.row, got.col, got.value);
            end else begin
                want = pending_elems.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp r%0d c%0d %h sing %b sat %b last %b, got r%0d c%0d %h sing %b sat %b last %b",
                                 want.row, want.col, want.value, want.singular,
                                 want.saturated, want.last, got.row, got.col, got.value,
                                 got.singular, got.saturated, got.last);
                end
            end
        end
    end

    dir_row_t dir_rows [] = '{
        '{'{CMD_LOAD_SRC, 0, 0, 16'h0100}, 0, 0, 0, 0},
        '{'{CMD_LOAD_DST, 0, 0, 16'h0100}, 0, 0, 0, 0},
        '{'{CMD_SOLVE,    0, 0, 16'h0000}, 1, 32'h0001_0000, 0, 0},
        '{'{CMD_LOAD_SRC, 0, 0, 16'h0000}, 0, 0, 0, 0},
        '{'{CMD_SOLVE,    3, 3, 16'hFFFF}, 1, 32'h0000_0000, 1, 0},
        '{'{CMD_LOAD_SRC, 0, 0, 16'h0001}, 0, 0, 0, 0},
        '{'{CMD_LOAD_DST, 0, 0, 16'h7FFF}, 0, 0, 0, 0},
        '{'{CMD_SOLVE,    0, 0, 16'h0000}, 1, 32'h7FFF_0000, 0, 0},
        '{'{CMD_LOAD_DST, 0, 0, 16'h8000}, 0, 0, 0, 0},
        '{'{CMD_SOLVE,    0, 0, 16'h0000}, 1, 32'h8000_0000, 0, 0},
        '{'{CMD_LOAD_SRC, 0, 0, 16'hFFFF}, 0, 0, 0, 0},
        '{'{CMD_SOLVE,    0, 0, 16'h0000}, 1, 32'h7FFF_FFFF, 0, 1},
        '{'{CMD_SPARE,    3, 3, 16'hFFFF}, 0, 0, 0, 0},
        '{'{CMD_LOAD_SRC, 3, 3, 16'h7FFF}, 0, 0, 0, 0},
        '{'{CMD_LOAD_DST, 3, 3, 16'hFFFF}, 0, 0, 0, 0},
        '{'{CMD_LOAD_SRC, 0, 0, 16'h7FFF}, 0, 0, 0, 0},
        '{'{CMD_LOAD_DST, 0, 0, 16'h0001}, 0, 0, 0, 0},
        '{'{CMD_SOLVE,    0, 0, 16'h0000}, 0, 0, 0, 0},
        '{'{CMD_LOAD_SRC, 0, 0, 16'h8000}, 0, 0, 0, 0},
        '{'{CMD_LOAD_DST, 0, 0, 16'h0300}, 0, 0, 0, 0},
        '{'{CMD_SOLVE,    0, 0, 16'h0000}, 0, 0, 0, 0}
    };

    initial begin
        logic [2:0] size_plan [] = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd3};
        logic [2:0] sz;
        beat_t      b;
        elem_t      e;
        int         mode;
        int         phase;
        mismatches = 0;
        items_sent = 0;
        burst_left = 0;
        dim = 4;
        start = 1'b0;
        i_command = CMD_LOAD_SRC;
        i_row_index = '0;
        i_col_index = '0;
        i_element_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_size(3'd1);
        foreach (dir_rows[k]) begin
            send(dir_rows[k].b, !dir_rows[k].typed);
            if (dir_rows[k].typed) begin
                e = '{row: 0, col: 0, value: dir_rows[k].xvalue,
                      singular: dir_rows[k].xsing, saturated: dir_rows[k].xsat, last: 1};
                pending_elems.push_back(e);
            end
        end

        phase = 0;
        while (items_sent < 420) begin
            sz = phase < size_plan.size() ? size_plan[phase] : 3'($urandom_range(0, 7));
            write_size(sz);
            phase++;
            repeat ($urandom_range(2, 5)) begin
                // A full load of both matrices with random content, then a solve.
                mode = $urandom_range(0, 2);
                for (int r = 0; r < dim; r++) begin
                    for (int c = 0; c < dim; c++) begin
                        send('{CMD_LOAD_SRC, 2'(r), 2'(c), rand_elem(mode)});
                        send('{CMD_LOAD_DST, 2'(r), 2'(c), rand_elem($urandom_range(0, 2))});
                    end
                end
                // Now and then make the source singular.
                if ($urandom_range(0, 4) == 0) begin
                    for (int r = 0; r < dim; r++)
                        send('{CMD_LOAD_SRC, 2'(r), 2'(dim > 1 ? 1 : 0),
                               dim > 1 ? src_mat[r][0] : 16'h0000});
                end
                // Some noise: stray loads anywhere and the spare command.
                repeat ($urandom_range(0, 3)) begin
                    b.cmd = $urandom_range(0, 3) == 3 ? CMD_SPARE
                          : ($urandom_range(0, 1) ? CMD_LOAD_DST : CMD_LOAD_SRC);
                    b.row = 2'($urandom);
                    b.col = 2'($urandom);
                    b.val = 16'($urandom);
                    send(b);
                end
                send('{CMD_SOLVE, 2'($urandom), 2'($urandom), 16'($urandom)});
            end
        end

        drain();
        if (mismatches == 0 && pending_elems.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
